@@ hw/rtl/bfha_pkg.sv @@
// Shared constants, types and codes of the best-fit heap allocator.
`timescale 1ns / 1ps
package bfha_pkg;

    localparam int NB        = 64;
    localparam int IDX_W     = $clog2(NB);
    localparam int OFF_W     = 29;
    localparam int SZ_W      = 28;
    localparam int REC_W     = 7;
    localparam int ALN_W     = 33;
    localparam int WORD_W    = 2 * SZ_W + REC_W;

    localparam logic [OFF_W-1:0] HEAP_BYTES     = 29'd268435456;
    localparam logic [SZ_W-1:0]  HEAP_USER      = 28'd268435416;
    localparam logic [SZ_W-1:0]  BLOCK_OVERHEAD = 28'd40;
    localparam logic [SZ_W-1:0]  SPLIT_TAKE     = 28'd40;
    localparam logic [OFF_W-1:0] HEAD_BYTES     = 29'd36;
    localparam logic [ALN_W-1:0] MIN_UNIT       = 33'd128;
    localparam logic [ALN_W-1:0] ALIGN_MASK     = 33'd7;
    localparam logic [ALN_W:0]   SPLIT_MARGIN   = 34'd168;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_REINIT = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_NOMEM   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_DOUBLE  = 3'd4;
    localparam logic [2:0] ST_REINIT  = 3'd5;

    localparam logic [2:0] OP_SCAN_BEST   = 3'd0;
    localparam logic [2:0] OP_SCAN_FIND   = 3'd1;
    localparam logic [2:0] OP_SCAN_NEXT   = 3'd2;
    localparam logic [2:0] OP_UNLINK_BEST = 3'd3;
    localparam logic [2:0] OP_LINK_SLOT   = 3'd4;
    localparam logic [2:0] OP_LINK_BLK    = 3'd5;
    localparam logic [2:0] OP_UNLINK_NEXT = 3'd6;

    typedef struct packed {
        logic [1:0]       mode;
        logic [31:0]      request_size;
        logic [OFF_W-1:0] user_offset;
    } req_t;

    typedef struct packed {
        logic [OFF_W-1:0] result_offset;
        logic [2:0]       status;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       init;
        logic       start;
        logic [2:0] op;
        logic       out_load;
        logic [2:0] out_status;
        logic       out_ptr;
    } dp_cmd_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [1:0] mode;
        logic       req_zero;
        logic       off_zero;
        logic       a_found;
        logic       a_free;
        logic       split_ok;
        logic       nxt_out;
        logic       b_found;
    } dp_stat_t;

endpackage

@@ hw/rtl/bfha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/bfha_dp.sv @@
// Datapath: block table, entry sweeps, best-fit search and result register.
`timescale 1ns / 1ps
module bfha_dp
    import bfha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    input  req_t     req,
    output dp_stat_t stat,
    output rsp_t     rsp
);

    logic [NB-1:0]    valid_reg;
    logic [NB-1:0]    free_reg;
    req_t             req_reg;
    logic [ALN_W-1:0] aligned_reg;
    logic [2:0]       op_reg;
    logic             run_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             proc_vld_reg;
    logic [IDX_W-1:0] proc_idx_reg;
    logic             a_found_reg;
    logic [IDX_W-1:0] a_idx_reg;
    logic [SZ_W-1:0]  a_start_reg;
    logic [SZ_W-1:0]  a_size_reg;
    logic [REC_W-1:0] a_rec_reg;
    logic             b_found_reg;
    logic [IDX_W-1:0] b_idx_reg;
    logic [SZ_W-1:0]  b_size_reg;
    logic [REC_W-1:0] b_rec_reg;
    logic             slot_found_reg;
    logic [IDX_W-1:0] slot_idx_reg;
    rsp_t             rsp_reg;

    logic [ALN_W-1:0]  round_up;
    logic [ALN_W-1:0]  aligned_next;
    logic [WORD_W-1:0] rd_word;
    logic [SZ_W-1:0]   w_start;
    logic [SZ_W-1:0]   w_size;
    logic [REC_W-1:0]  w_rec;
    logic              w_v;
    logic              w_f;
    logic              done;
    logic              is_sweep;
    logic              inc;
    logic [IDX_W-1:0]  excl_idx;
    logic [IDX_W-1:0]  patch_idx;
    logic [REC_W-1:0]  thr;
    logic [WORD_W-1:0] patch_word;
    logic              adj;
    logic              patch_hit;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [SZ_W-1:0]   split_start;
    logic [SZ_W-1:0]   split_size;
    logic [SZ_W-1:0]   merge_size;
    logic [OFF_W-1:0]  nxt;
    logic              fits;
    logic              better;

    assign round_up     = ({1'b0, req.request_size} + ALIGN_MASK) & ~ALIGN_MASK;
    assign aligned_next = (round_up < MIN_UNIT) ? MIN_UNIT : round_up;

    assign w_start = rd_word[WORD_W-1 -: SZ_W];
    assign w_size  = rd_word[REC_W +: SZ_W];
    assign w_rec   = rd_word[REC_W-1:0];
    assign w_v     = valid_reg[proc_idx_reg];
    assign w_f     = free_reg[proc_idx_reg];
    assign done    = proc_vld_reg && (proc_idx_reg == IDX_W'(NB - 1));

    assign split_start = a_start_reg + aligned_reg[SZ_W-1:0] + BLOCK_OVERHEAD;
    assign split_size  = a_size_reg - aligned_reg[SZ_W-1:0] - SPLIT_TAKE;
    assign merge_size  = a_size_reg + BLOCK_OVERHEAD + b_size_reg;
    assign nxt         = {1'b0, a_start_reg} + {1'b0, BLOCK_OVERHEAD} + {1'b0, a_size_reg};

    assign fits   = {{(ALN_W-SZ_W){1'b0}}, w_size} >= aligned_reg;
    assign better = !a_found_reg || (w_size < a_size_reg)
                    || ((w_size == a_size_reg) && (w_rec < a_rec_reg));

    // Per-sweep target, exclusion and recency update
    always_comb
    begin
        is_sweep   = 1'b1;
        inc        = 1'b0;
        excl_idx   = a_idx_reg;
        patch_idx  = a_idx_reg;
        thr        = a_rec_reg;
        patch_word = {a_start_reg, a_size_reg, {REC_W{1'b0}}};
        unique case (op_reg)
            OP_UNLINK_BEST:
            begin
                patch_word = {a_start_reg, aligned_reg[SZ_W-1:0], {REC_W{1'b0}}};
            end
            OP_LINK_SLOT:
            begin
                inc        = 1'b1;
                excl_idx   = slot_idx_reg;
                patch_idx  = slot_idx_reg;
                patch_word = {split_start, split_size, {REC_W{1'b0}}};
            end
            OP_LINK_BLK:
            begin
                inc = 1'b1;
            end
            OP_UNLINK_NEXT:
            begin
                excl_idx   = b_idx_reg;
                thr        = b_rec_reg;
                patch_word = {a_start_reg, merge_size, {REC_W{1'b0}}};
            end
            default:
            begin
                is_sweep = 1'b0;
            end
        endcase
    end

    assign adj       = w_v && w_f && (proc_idx_reg != excl_idx) && (inc || (w_rec > thr));
    assign patch_hit = proc_idx_reg == patch_idx;

    always_comb
    begin
        ram_we    = proc_vld_reg && is_sweep && (patch_hit || adj);
        ram_waddr = proc_idx_reg;
        ram_wdata = patch_hit ? patch_word
                    : {w_start, w_size, inc ? w_rec + 1'b1 : w_rec - 1'b1};
        if (cmd.init)
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {{SZ_W{1'b0}}, HEAP_USER, {REC_W{1'b0}}};
        end
    end

    bfha_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NB)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (run_reg),
        .raddr (addr_reg),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            free_reg       <= '0;
            req_reg        <= '0;
            aligned_reg    <= '0;
            op_reg         <= OP_SCAN_BEST;
            run_reg        <= 1'b0;
            addr_reg       <= '0;
            proc_vld_reg   <= 1'b0;
            proc_idx_reg   <= '0;
            a_found_reg    <= 1'b0;
            a_idx_reg      <= '0;
            a_start_reg    <= '0;
            a_size_reg     <= '0;
            a_rec_reg      <= '0;
            b_found_reg    <= 1'b0;
            b_idx_reg      <= '0;
            b_size_reg     <= '0;
            b_rec_reg      <= '0;
            slot_found_reg <= 1'b0;
            slot_idx_reg   <= '0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                req_reg     <= req;
                aligned_reg <= aligned_next;
            end
            if (cmd.init)
            begin
                valid_reg <= {{(NB-1){1'b0}}, 1'b1};
                free_reg  <= {{(NB-1){1'b0}}, 1'b1};
            end

            // Sweep address generator
            if (cmd.start)
            begin
                op_reg   <= cmd.op;
                run_reg  <= 1'b1;
                addr_reg <= '0;
                if (cmd.op == OP_SCAN_BEST || cmd.op == OP_SCAN_FIND)
                begin
                    a_found_reg    <= 1'b0;
                    slot_found_reg <= 1'b0;
                end
                if (cmd.op == OP_SCAN_NEXT)
                begin
                    b_found_reg <= 1'b0;
                end
            end
            else if (run_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (addr_reg == IDX_W'(NB - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
            proc_vld_reg <= run_reg;
            proc_idx_reg <= addr_reg;

            if (proc_vld_reg)
            begin
                unique case (op_reg)
                    OP_SCAN_BEST:
                    begin
                        if (w_v && w_f && fits && better)
                        begin
                            a_found_reg <= 1'b1;
                            a_idx_reg   <= proc_idx_reg;
                            a_start_reg <= w_start;
                            a_size_reg  <= w_size;
                            a_rec_reg   <= w_rec;
                        end
                        if (!w_v && !slot_found_reg)
                        begin
                            slot_found_reg <= 1'b1;
                            slot_idx_reg   <= proc_idx_reg;
                        end
                    end
                    OP_SCAN_FIND:
                    begin
                        if (w_v && !a_found_reg
                            && ({1'b0, w_start} + HEAD_BYTES == req_reg.user_offset))
                        begin
                            a_found_reg <= 1'b1;
                            a_idx_reg   <= proc_idx_reg;
                            a_start_reg <= w_start;
                            a_size_reg  <= w_size;
                        end
                    end
                    OP_SCAN_NEXT:
                    begin
                        if (w_v && w_f && !b_found_reg && (proc_idx_reg != a_idx_reg)
                            && ({1'b0, w_start} == nxt))
                        begin
                            b_found_reg <= 1'b1;
                            b_idx_reg   <= proc_idx_reg;
                            b_size_reg  <= w_size;
                            b_rec_reg   <= w_rec;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Flag updates, and the merged size, at the end of a sweep
            if (done)
            begin
                unique case (op_reg)
                    OP_UNLINK_BEST:
                    begin
                        free_reg[a_idx_reg] <= 1'b0;
                    end
                    OP_LINK_SLOT:
                    begin
                        valid_reg[slot_idx_reg] <= 1'b1;
                        free_reg[slot_idx_reg]  <= 1'b1;
                    end
                    OP_LINK_BLK:
                    begin
                        free_reg[a_idx_reg] <= 1'b1;
                    end
                    OP_UNLINK_NEXT:
                    begin
                        valid_reg[b_idx_reg] <= 1'b0;
                        free_reg[b_idx_reg]  <= 1'b0;
                        a_size_reg           <= merge_size;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.out_load)
            begin
                rsp_reg.status        <= cmd.out_status;
                rsp_reg.result_offset <= cmd.out_ptr ? ({1'b0, a_start_reg} + HEAD_BYTES)
                                                     : '0;
            end
        end
    end

    always_comb
    begin
        stat.busy     = run_reg || proc_vld_reg;
        stat.done     = done;
        stat.mode     = req_reg.mode;
        stat.req_zero = req_reg.request_size == '0;
        stat.off_zero = req_reg.user_offset == '0;
        stat.a_found  = a_found_reg;
        stat.a_free   = free_reg[a_idx_reg];
        stat.split_ok = slot_found_reg
                        && ({{(ALN_W-SZ_W+1){1'b0}}, a_size_reg}
                            >= ({1'b0, aligned_reg} + SPLIT_MARGIN));
        stat.nxt_out  = nxt >= HEAP_BYTES;
        stat.b_found  = b_found_reg;
    end

    assign rsp = rsp_reg;

endmodule

@@ hw/rtl/bfha_ctrl.sv @@
// Controller: request sequencing through scans and sweeps, response handshake.
`timescale 1ns / 1ps
module bfha_ctrl
    import bfha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_RST   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_ASCAN = 4'd3;
    localparam logic [3:0] S_ACHK  = 4'd4;
    localparam logic [3:0] S_AUNL  = 4'd5;
    localparam logic [3:0] S_ASPL  = 4'd6;
    localparam logic [3:0] S_ALNK  = 4'd7;
    localparam logic [3:0] S_FFIND = 4'd8;
    localparam logic [3:0] S_FCHK  = 4'd9;
    localparam logic [3:0] S_FLNK  = 4'd10;
    localparam logic [3:0] S_FNCHK = 4'd11;
    localparam logic [3:0] S_FNXT  = 4'd12;
    localparam logic [3:0] S_FMCHK = 4'd13;
    localparam logic [3:0] S_FUNL  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [2:0] st_reg, st_next;
    logic       ptr_reg, ptr_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        ptr_next   = ptr_reg;
        cmd        = '0;
        unique case (state_reg)
            S_RST:
            begin
                cmd.init   = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                ptr_next   = 1'b0;
                st_next    = ST_IGNORED;
                state_next = S_OUT;
                priority if (stat.mode == MODE_ALLOC && !stat.req_zero)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SCAN_BEST;
                    state_next = S_ASCAN;
                end
                else if (stat.mode == MODE_FREE && !stat.off_zero)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SCAN_FIND;
                    state_next = S_FFIND;
                end
                else if (stat.mode == MODE_REINIT)
                begin
                    cmd.init = 1'b1;
                    st_next  = ST_REINIT;
                end
                else
                begin
                end
            end
            S_ASCAN:
            begin
                if (stat.done)
                begin
                    state_next = S_ACHK;
                end
            end
            S_ACHK:
            begin
                if (!stat.a_found)
                begin
                    st_next    = ST_NOMEM;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_UNLINK_BEST;
                    state_next = S_AUNL;
                end
            end
            S_AUNL:
            begin
                if (stat.done)
                begin
                    state_next = S_ASPL;
                end
            end
            S_ASPL:
            begin
                st_next  = ST_OK;
                ptr_next = 1'b1;
                if (stat.split_ok)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_LINK_SLOT;
                    state_next = S_ALNK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_ALNK, S_FUNL:
            begin
                st_next = ST_OK;
                if (stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_FFIND:
            begin
                if (stat.done)
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                priority if (!stat.a_found)
                begin
                    st_next    = ST_INVALID;
                    state_next = S_OUT;
                end
                else if (stat.a_free)
                begin
                    st_next    = ST_DOUBLE;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_LINK_BLK;
                    state_next = S_FLNK;
                end
            end
            S_FLNK:
            begin
                if (stat.done)
                begin
                    state_next = S_FNCHK;
                end
            end
            S_FNCHK:
            begin
                st_next = ST_OK;
                if (stat.nxt_out)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_FNXT;
                end
            end
            S_FNXT:
            begin
                if (stat.done)
                begin
                    state_next = S_FMCHK;
                end
            end
            S_FMCHK:
            begin
                st_next = ST_OK;
                if (stat.b_found)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_UNLINK_NEXT;
                    state_next = S_FUNL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the response register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = st_reg;
                    cmd.out_ptr    = ptr_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST;
            st_reg        <= ST_OK;
            ptr_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ hw/rtl/best_fit_heap_allocator.sv @@
// Best-fit heap allocator: top level joining controller and datapath.
// One request at a time. Each pass walks the 64-entry block table held in a
// single-port-read RAM, one entry per cycle: an allocate takes one search pass
// plus, if a block is found, one or two recency passes, and a free takes up to
// four passes; a zero request, a null free, mode three and a reinit take no
// pass. After reset the block writes the initial free block before it takes a
// request. A finished response waits in an output register while the next
// request is taken.
`timescale 1ns / 1ps
module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bfha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfha_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .rsp   (rsp)
    );

    // A request is never taken while a table pass is still running
    a_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |-> !stat.busy)
        else $error("request accepted during a table pass");

    // The controller leaves idle right after taking a request
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("controller stayed idle after a request");

    // A pass only starts from a quiet datapath
    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.busy)
        else $error("pass started while another was running");

endmodule
